// ===== hw/rtl/sfp_pkg.sv =====
package sfp_pkg;

  localparam int FRAME_SAMPLES = 1024;
  localparam int POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_SAMPLES - 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam int CFG_AW = 3;
  localparam logic CFG_IDX_FLAGS = 1'b0;

  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h55;
  localparam logic [7:0] PAD_BYTE  = 8'h00;

  // byte positions within the per-item sequence
  localparam logic [3:0] B_HDR0  = 4'd0;
  localparam logic [3:0] B_HDR1  = 4'd1;
  localparam logic [3:0] B_SEQ0  = 4'd2;
  localparam logic [3:0] B_SEQ1  = 4'd3;
  localparam logic [3:0] B_SEQ2  = 4'd4;
  localparam logic [3:0] B_SEQ3  = 4'd5;
  localparam logic [3:0] B_TS0   = 4'd6;
  localparam logic [3:0] B_TS1   = 4'd7;
  localparam logic [3:0] B_TS2   = 4'd8;
  localparam logic [3:0] B_TS3   = 4'd9;
  localparam logic [3:0] B_FLAGS = 4'd10;
  localparam logic [3:0] B_PAD   = 4'd11;
  localparam logic [3:0] B_SMP0  = 4'd12;
  localparam logic [3:0] B_SMP1  = 4'd13;
  localparam logic [3:0] B_CS0   = 4'd14;
  localparam logic [3:0] B_CS1   = 4'd15;

  typedef struct packed {
    logic [15:0] sample_value;
    logic [31:0] time_stamp;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        first;
    logic        last;
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  flags;
    logic [15:0] csum;
  } job_t;

endpackage

// ===== hw/rtl/sample_frame_packetizer_top.sv =====
// Channel   Handshake                 Payload
// input     push / full               in_item  (sample_value, time_stamp)
// output    pop / empty               out_item (out_byte, run_last, frame_end)
// config    psel/penable/pwrite/pready paddr, pwdata, prdata (frame_flags at 0x0)
//
// One output byte per cycle from the byte sequencer while a job is queued and pop
// drains; an item yields 2 bytes (14 on a frame's first sample, 4 on its last,
// 16 for one-sample frames). A 4-deep job queue sits between front and back;
// a 1024-item frame is 2062 bytes, so a faster source sees full after each header.
// Synchronous active-low reset clears position, sequence, checksum and flags.
// Input stalls only when the job queue is full; output holds while pop is low.
module sample_frame_packetizer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  sfp_pkg::in_t              in_item,
  input  logic                      pop,
  output logic                      empty,
  output sfp_pkg::out_t             out_item,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic          acc;
  logic [7:0]    flags_r;
  sfp_pkg::job_t job_in, job_head;
  logic          q_full, q_empty, head_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sfp_pkg::CFG_IDX_FLAGS) ? {24'h0, flags_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == sfp_pkg::CFG_IDX_FLAGS) begin
      flags_r <= pwdata[7:0];
    end
  end

  assign full = q_full;
  assign acc  = push && !q_full;

  sfp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_item),
    .flags (flags_r),
    .job   (job_in)
  );

  sfp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (acc),
    .wdata   (job_in),
    .rd      (head_pop),
    .rdata   (job_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  sfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (job_head),
    .head_vld (!q_empty),
    .head_pop (head_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

// ===== hw/rtl/sfp_front.sv =====
module sfp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  sfp_pkg::in_t  item,
  input  logic [7:0]    flags,
  output sfp_pkg::job_t job
);

  logic [sfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [15:0] xor_r, xor_nxt;
  logic        first, last;
  logic [15:0] base;

  always_comb begin
    first = (pos_r == '0);
    last  = (pos_r == sfp_pkg::POS_LAST);
    base  = first ? (seq_r[15:0] ^ seq_r[31:16] ^ item.time_stamp[15:0]
                     ^ item.time_stamp[31:16] ^ {8'h00, flags})
                  : xor_r;
    xor_nxt = base ^ item.sample_value;
    pos_nxt = last ? '0 : pos_r + 1'b1;
    seq_nxt = last ? seq_r + 32'd1 : seq_r;

    job.sample = item.sample_value;
    job.first  = first;
    job.last   = last;
    job.seq    = seq_r;
    job.stamp  = item.time_stamp;
    job.flags  = flags;
    job.csum   = xor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      seq_r <= '0;
      xor_r <= '0;
    end else if (acc) begin
      pos_r <= pos_nxt;
      seq_r <= seq_nxt;
      xor_r <= xor_nxt;
    end
  end

endmodule

// ===== hw/rtl/sfp_fifo.sv =====
module sfp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  sfp_pkg::job_t wdata,
  input  logic          rd,
  output sfp_pkg::job_t rdata,
  output logic          q_full,
  output logic          q_empty
);

  sfp_pkg::job_t mem [sfp_pkg::Q_DEPTH];
  logic [sfp_pkg::Q_AW-1:0] wp_r, rp_r;
  logic [sfp_pkg::Q_AW:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == (sfp_pkg::Q_AW+1)'(sfp_pkg::Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rdata   = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !rd |-> !wr) else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !rd) else $error("queue read while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (sfp_pkg::Q_AW+1)'(sfp_pkg::Q_DEPTH)) else $error("queue count out of range");

endmodule

// ===== hw/rtl/sfp_back.sv =====
module sfp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sfp_pkg::job_t head,
  input  logic          head_vld,
  output logic          head_pop,
  input  logic          pop,
  output logic          empty,
  output sfp_pkg::out_t out_item
);

  logic          active_r, active_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic          ovld_r, ovld_nxt;
  sfp_pkg::out_t out_r;
  logic [3:0]    idx_cur, idx_end;
  logic          load;
  logic [7:0]    byte_sel;

  assign empty    = !ovld_r;
  assign out_item = out_r;

  always_comb begin
    idx_cur = active_r ? idx_r : (head.first ? sfp_pkg::B_HDR0 : sfp_pkg::B_SMP0);
    idx_end = head.last ? sfp_pkg::B_CS1 : sfp_pkg::B_SMP1;
    load    = head_vld && (!ovld_r || pop);

    case (idx_cur)
      sfp_pkg::B_HDR0:  byte_sel = sfp_pkg::HDR_BYTE0;
      sfp_pkg::B_HDR1:  byte_sel = sfp_pkg::HDR_BYTE1;
      sfp_pkg::B_SEQ0:  byte_sel = head.seq[7:0];
      sfp_pkg::B_SEQ1:  byte_sel = head.seq[15:8];
      sfp_pkg::B_SEQ2:  byte_sel = head.seq[23:16];
      sfp_pkg::B_SEQ3:  byte_sel = head.seq[31:24];
      sfp_pkg::B_TS0:   byte_sel = head.stamp[7:0];
      sfp_pkg::B_TS1:   byte_sel = head.stamp[15:8];
      sfp_pkg::B_TS2:   byte_sel = head.stamp[23:16];
      sfp_pkg::B_TS3:   byte_sel = head.stamp[31:24];
      sfp_pkg::B_FLAGS: byte_sel = head.flags;
      sfp_pkg::B_PAD:   byte_sel = sfp_pkg::PAD_BYTE;
      sfp_pkg::B_SMP0:  byte_sel = head.sample[7:0];
      sfp_pkg::B_SMP1:  byte_sel = head.sample[15:8];
      sfp_pkg::B_CS0:   byte_sel = head.csum[7:0];
      sfp_pkg::B_CS1:   byte_sel = head.csum[15:8];
      default:          byte_sel = sfp_pkg::PAD_BYTE;
    endcase

    head_pop   = load && (idx_cur == idx_end);
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (load) begin
      active_nxt = !head_pop;
      idx_nxt    = idx_cur + 4'd1;
    end

    ovld_nxt = ovld_r;
    if (load) begin
      ovld_nxt = 1'b1;
    end else if (pop) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_byte  <= byte_sel;
      out_r.run_last  <= (idx_cur == idx_end);
      out_r.frame_end <= (idx_cur == sfp_pkg::B_CS1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      ovld_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && out_r.frame_end |-> out_r.run_last) else $error("frame end not item end");

  a_active_head: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> head_vld) else $error("mid-item with empty queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> ovld_r && out_r.run_last) else $error("item retired without last byte");

endmodule
